// ===== hdl/dtf8_pkg.sv =====
package dtf8_pkg;

    typedef enum logic [1:0] {
        ST_OK,
        ST_SYNTAX,
        ST_OVERFLOW,
        ST_DECIMALS
    } t_status;

    localparam logic [7:0] CH_DOT  = 8'h2e;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Power of ten for elaboration-time constants; n at most 19.
    function automatic logic [63:0] dtf8_pow10(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

endpackage

// ===== hdl/dtf8_if.sv =====
interface dtf8_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       has_char;
    logic       last;

    modport source (output valid, output ch, output has_char, output last, input ready);
    modport sink   (input valid, input ch, input has_char, input last, output ready);
endinterface

interface dtf8_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] amount;
    logic [1:0]  status;

    modport source (output valid, output amount, output status, input ready);
    modport sink   (input valid, input amount, input status, output ready);
endinterface

// ===== hdl/dtf8_accum.sv =====
module dtf8_accum #(
    parameter int NUM_DECIMALS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dtf8_in_if.sink           i_in,
    input  logic              i_fin_ready,
    output logic              o_fin_valid,
    output logic [63+$clog2(dtf8_pkg::dtf8_pow10(NUM_DECIMALS)):0] o_fin_scaled,
    output logic [$clog2(dtf8_pkg::dtf8_pow10(NUM_DECIMALS))-1:0]  o_fin_frac,
    output dtf8_pkg::t_status o_fin_status
);
    import dtf8_pkg::*;

    localparam logic [63:0] SCALE = dtf8_pow10(NUM_DECIMALS);
    localparam int FW  = $clog2(SCALE);
    localparam int WSW = 64 + FW;
    localparam int CW  = $clog2(NUM_DECIMALS + 1);
    localparam int IW  = (NUM_DECIMALS > 1) ? $clog2(NUM_DECIMALS) : 1;
    localparam int TD  = 1 << IW;

    logic           r_in_valid;
    logic [7:0]     r_ch;
    logic           r_has;
    logic           r_last;

    logic [63:0]    r_whole, n_whole;
    logic [WSW-1:0] r_ws, n_ws;
    logic [FW-1:0]  r_fp, n_fp;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_dot, n_dot;
    logic           r_digit, n_digit;
    t_status        r_err, n_err;

    logic [FW-1:0]  pow_tab [TD];
    logic           fire;
    logic           is_digit;
    logic [3:0]     d;
    logic [67:0]    w68;
    logic [67:0]    whole_x;
    logic [67:0]    d_scaled;
    logic [WSW-1:0] ws_x;
    logic [FW-1:0]  fp_x;

    for (genvar g = 0; g < TD; g++) begin : g_pow
        if (g < NUM_DECIMALS) begin : g_used
            assign pow_tab[g] = FW'(dtf8_pow10(NUM_DECIMALS - 1 - g));
        end else begin : g_unused
            assign pow_tab[g] = '0;
        end
    end

    assign fire       = r_in_valid && (!r_last || i_fin_ready);
    assign i_in.ready = !r_in_valid || fire;

    assign is_digit = (r_ch >= CH_ZERO) && (r_ch <= CH_NINE);
    assign d        = r_ch[3:0];
    assign w68      = {4'b0, r_whole};
    assign whole_x  = {w68[64:0], 3'b0} + {w68[66:0], 1'b0} + {64'b0, d};
    assign d_scaled = {64'b0, d} * {4'b0, SCALE};
    assign ws_x     = {r_ws[WSW-4:0], 3'b0} + {r_ws[WSW-2:0], 1'b0} + WSW'(d_scaled);
    assign fp_x     = r_fp + FW'(d) * pow_tab[r_cnt[IW-1:0]];

    always_comb begin
        n_whole = r_whole;
        n_ws    = r_ws;
        n_fp    = r_fp;
        n_cnt   = r_cnt;
        n_dot   = r_dot;
        n_digit = r_digit;
        n_err   = r_err;
        if (r_has && r_err == ST_OK) begin
            if (r_ch == CH_DOT) begin
                if (r_dot) begin
                    n_err = ST_SYNTAX;
                end else begin
                    n_dot = 1'b1;
                end
            end else if (!is_digit) begin
                n_err = ST_SYNTAX;
            end else begin
                n_digit = 1'b1;
                if (!r_dot) begin
                    if (|whole_x[67:64]) begin
                        n_err = ST_OVERFLOW;
                    end else begin
                        n_whole = whole_x[63:0];
                        n_ws    = ws_x;
                    end
                end else if (r_cnt < CW'(NUM_DECIMALS)) begin
                    n_fp  = fp_x;
                    n_cnt = r_cnt + CW'(1);
                end else if (d != 4'd0) begin
                    n_err = ST_DECIMALS;
                end
            end
        end
    end

    assign o_fin_valid  = r_in_valid && r_last;
    assign o_fin_scaled = n_ws;
    assign o_fin_frac   = n_fp;
    assign o_fin_status = (n_err == ST_OK && !n_digit) ? ST_SYNTAX : n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_ch  <= i_in.ch;
            r_has <= i_in.has_char;
            r_last <= i_in.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && r_last)) begin
            r_whole <= '0;
            r_ws    <= '0;
            r_fp    <= '0;
            r_cnt   <= '0;
            r_dot   <= 1'b0;
            r_digit <= 1'b0;
            r_err   <= ST_OK;
        end else if (fire) begin
            r_whole <= n_whole;
            r_ws    <= n_ws;
            r_fp    <= n_fp;
            r_cnt   <= n_cnt;
            r_dot   <= n_dot;
            r_digit <= n_digit;
            r_err   <= n_err;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(NUM_DECIMALS))
        else $error("fraction count beyond the kept digits");

    a_cnt_needs_dot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != '0 |-> r_dot)
        else $error("fraction digits kept without a dot");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_OK && !(fire && r_last)) |=> r_err == $past(r_err))
        else $error("error code changed before the end of the text");

endmodule

// ===== hdl/dtf8_final.sv =====
module dtf8_final #(
    parameter int NUM_DECIMALS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fin_valid,
    input  logic [63+$clog2(dtf8_pkg::dtf8_pow10(NUM_DECIMALS)):0] i_fin_scaled,
    input  logic [$clog2(dtf8_pkg::dtf8_pow10(NUM_DECIMALS))-1:0]  i_fin_frac,
    input  dtf8_pkg::t_status i_fin_status,
    output logic              o_fin_ready,
    dtf8_out_if.source        o_out
);
    import dtf8_pkg::*;

    localparam int FW  = $clog2(dtf8_pow10(NUM_DECIMALS));
    localparam int WSW = 64 + FW;

    logic           r_fin_valid;
    logic [WSW-1:0] r_fs;
    logic [FW-1:0]  r_ff;
    t_status        r_fst;

    logic           r_out_valid;
    logic [63:0]    r_out_amount;
    t_status        r_out_status;

    logic           out_free;
    logic           move;
    logic [WSW:0]   sum;
    t_status        n_status;

    assign out_free    = !r_out_valid || o_out.ready;
    assign move        = r_fin_valid && out_free;
    assign o_fin_ready = !r_fin_valid || out_free;

    assign sum      = {1'b0, r_fs} + (WSW + 1)'(r_ff);
    assign n_status = (r_fst != ST_OK) ? r_fst : ((|sum[WSW:64]) ? ST_OVERFLOW : ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (i_fin_valid && o_fin_ready) begin
            r_fin_valid <= 1'b1;
        end else if (move) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fin_valid && o_fin_ready) begin
            r_fs  <= i_fin_scaled;
            r_ff  <= i_fin_frac;
            r_fst <= i_fin_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_amount <= (n_status == ST_OK) ? sum[63:0] : 64'd0;
            r_out_status <= n_status;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.amount = r_out_amount;
    assign o_out.status = r_out_status;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> r_out_amount == 64'd0)
        else $error("nonzero amount with an error status");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> r_out_valid)
        else $error("finished item lost on its way to the output register");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready)
            |=> (r_out_valid && $stable(r_out_amount) && $stable(r_out_status)))
        else $error("waiting result changed before it was taken");

endmodule

// ===== hdl/decimal_text_to_fixed8_top.sv =====
// Channel  Direction  Payload                      Handshake
// i_in     in         ch[7:0], has_char, last      valid / ready
// o_out    out        amount[63:0], status[1:0]    valid / ready
//
// One character item is taken every cycle while ready is high; the per-character work is one
// multiply-by-ten step in the input stage.
// The result of an item with last set goes from the input stage to the finish
// register, and after the final add and overflow compare to the output register.
// Reset is synchronous and clears the stage valid bits and the parse state.
// Ready falls only when the output register holds an untaken result and
// the stages in front of it are full.
module decimal_text_to_fixed8_top #(
    parameter int NUM_DECIMALS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dtf8_in_if.sink     i_in,
    dtf8_out_if.source  o_out
);
    import dtf8_pkg::*;

    localparam int FW  = $clog2(dtf8_pow10(NUM_DECIMALS));
    localparam int WSW = 64 + FW;

    logic           fin_valid;
    logic           fin_ready;
    logic [WSW-1:0] fin_scaled;
    logic [FW-1:0]  fin_frac;
    t_status        fin_status;

    dtf8_accum #(
        .NUM_DECIMALS(NUM_DECIMALS)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_fin_ready  (fin_ready),
        .o_fin_valid  (fin_valid),
        .o_fin_scaled (fin_scaled),
        .o_fin_frac   (fin_frac),
        .o_fin_status (fin_status)
    );

    dtf8_final #(
        .NUM_DECIMALS(NUM_DECIMALS)
    ) u_final (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fin_valid  (fin_valid),
        .i_fin_scaled (fin_scaled),
        .i_fin_frac   (fin_frac),
        .i_fin_status (fin_status),
        .o_fin_ready  (fin_ready),
        .o_out        (o_out)
    );

endmodule
